### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the scroller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

### hw/rtl/lmts_pkg.sv
// Package of the LED matrix text scroller: constants, types and the font table.
package lmts_pkg;

   localparam int SLOTS       = 64;
   localparam int SLOT_AW     = $clog2(SLOTS);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_PERIOD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAR_COUNT    = 1'b1;

   localparam logic [15:0] SCROLL_PERIOD_RESET = 16'd500;
   localparam logic [5:0]  CHAR_COUNT_RESET    = 6'd11;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   localparam logic [7:0] CHAR_FIRST = 8'h41;
   localparam logic [7:0] CHAR_LAST  = 8'h5A;

   // What a glyph store slot holds: a letter flag and the font index.
   typedef struct packed {
      logic       letter;
      logic [4:0] index;
   } lmts_glyph_type;

   localparam int GLYPH_W = $bits(lmts_glyph_type);

   typedef struct packed {
      logic               is_load;
      logic               slot_ok;
      logic [SLOT_AW-1:0] slot;
      lmts_glyph_type     glyph;
   } lmts_entry_type;

   typedef struct packed {
      logic           valid;
      lmts_entry_type entry;
   } lmts_push_type;

   typedef struct packed {
      logic           valid;
      lmts_entry_type entry;
   } lmts_head_type;

   // Eight rows of a letter, row 0 in the low byte.
   function automatic logic [63:0] font_rows(logic [4:0] index);
      logic [63:0] rows;
      case (index)
         5'd0:    rows = 64'h0042_427E_4242_2418;
         5'd1:    rows = 64'h007C_4242_7C42_427C;
         5'd2:    rows = 64'h003C_4240_4040_423C;
         5'd3:    rows = 64'h007C_4242_4242_427C;
         5'd4:    rows = 64'h007E_4040_7C40_407E;
         5'd5:    rows = 64'h0040_4040_7C40_407E;
         5'd6:    rows = 64'h003C_4242_4E40_423C;
         5'd7:    rows = 64'h0042_4242_7E42_4242;
         5'd8:    rows = 64'h007E_1010_1010_107E;
         5'd9:    rows = 64'h0038_4444_0404_041E;
         5'd10:   rows = 64'h0042_4448_7048_4442;
         5'd11:   rows = 64'h007E_4040_4040_4040;
         5'd12:   rows = 64'h0042_4242_5A5A_6642;
         5'd13:   rows = 64'h0042_464E_5A72_6242;
         5'd14:   rows = 64'h003C_4242_4242_423C;
         5'd15:   rows = 64'h0040_4040_7C42_427C;
         5'd16:   rows = 64'h003A_464A_4242_423C;
         5'd17:   rows = 64'h0042_4448_7C42_427C;
         5'd18:   rows = 64'h003C_4202_3C40_423C;
         5'd19:   rows = 64'h0010_1010_1010_107E;
         5'd20:   rows = 64'h003C_4242_4242_4242;
         5'd21:   rows = 64'h0018_2424_4242_4242;
         5'd22:   rows = 64'h0042_665A_5A42_4242;
         5'd23:   rows = 64'h0042_4224_1824_4242;
         5'd24:   rows = 64'h0010_1010_1824_4242;
         5'd25:   rows = 64'h007E_2010_0804_027E;
         default: rows = '0;
      endcase
      return rows;
   endfunction

endpackage

### hw/rtl/lmts_req_if.sv
// Request channel interface: command items into the scroller.
interface lmts_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [5:0] slot_number;
   logic [7:0] char_code;

   modport source (output valid, command, slot_number, char_code, input ready);
   modport sink   (input valid, command, slot_number, char_code, output ready);
endinterface

### hw/rtl/lmts_rsp_if.sv
// Response channel interface: scanned rows out of the scroller.
interface lmts_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] row_select;
   logic [7:0] column_bits;

   modport source (output valid, row_select, column_bits, input ready);
   modport sink   (input valid, row_select, column_bits, output ready);
endinterface

### hw/rtl/led_matrix_text_scroller_top.sv
// Top level of the LED matrix text scroller: channels, registers, front, queue, back.
//
//   channel   direction  transfer when       payload
//   req_if    in         valid & ready      command, slot_number, char_code
//   rsp_if    out        valid & ready      row_select, column_bits
//   csr_*     in         csr_we             csr_index, csr_wdata (no read-back)
//
// Requests enter a 4-entry queue at one per cycle while it has room.
// The back end takes a load or a plain tick in ST_RUN; a tick that ends the
// scroll period goes on through ST_READ_B and ST_STEP, for two reads on the glyph RAM's one read port.
// Reset is synchronous; glyph slots read blank until loaded (per-slot valid bits).
// A stalled response holds the back end only on a tick; the queue keeps filling.
module led_matrix_text_scroller_top import lmts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lmts_req_if.sink              req_if,
   lmts_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [15:0]   scroll_period_ff, scroll_period_in;
   logic [5:0]    char_count_ff, char_count_in;
   lmts_push_type push;
   lmts_head_type head;
   logic          queue_full;
   logic          pop;

   always_comb begin
      scroll_period_in = scroll_period_ff;
      char_count_in    = char_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SCROLL_PERIOD: scroll_period_in = csr_wdata[15:0];
            CSR_CHAR_COUNT:    char_count_in    = csr_wdata[5:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_period_ff <= SCROLL_PERIOD_RESET;
         char_count_ff    <= CHAR_COUNT_RESET;
      end else begin
         scroll_period_ff <= scroll_period_in;
         char_count_ff    <= char_count_in;
      end
   end

   lmts_front u_front (
      .req_if     (req_if),
      .queue_full (queue_full),
      .push       (push)
   );

   lmts_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   lmts_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_if        (rsp_if),
      .scroll_period (scroll_period_ff),
      .char_count    (char_count_ff)
   );

endmodule

### hw/rtl/lmts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lmts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/lmts_front.sv
// Front end: takes request transfers, decodes letters and slot range for the queue.
module lmts_front import lmts_pkg::*; (
   lmts_req_if.sink      req_if,
   input  logic          queue_full,
   output lmts_push_type push
);

   logic letter;

   always_comb begin
      letter = (req_if.char_code >= CHAR_FIRST) && (req_if.char_code <= CHAR_LAST);

      push.valid              = req_if.valid && !queue_full;
      push.entry.is_load      = (req_if.command == CMD_LOAD);
      push.entry.slot_ok      = (32'(req_if.slot_number) < SLOTS);
      push.entry.slot         = SLOT_AW'(req_if.slot_number);
      push.entry.glyph.letter = letter;
      push.entry.glyph.index  = letter ? 5'(req_if.char_code - CHAR_FIRST) : 5'd0;
   end

   assign req_if.ready = !queue_full;

endmodule

### hw/rtl/lmts_queue.sv
// Short in-order queue between the front end and the back end.
`include "assert_macros.svh"
module lmts_queue import lmts_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  lmts_push_type push,
   input  logic          pop,
   output lmts_head_type head,
   output logic          full
);

   lmts_entry_type      entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;

   function automatic logic [QUEUE_AW-1:0] ptr_next(logic [QUEUE_AW-1:0] ptr);
      return (ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : QUEUE_AW'(ptr + 1'b1);
   endfunction

   always_comb begin
      wr_ptr_in = push.valid ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = QUEUE_CW'(count_ff + 1'b1);
      end else if (pop && !push.valid) begin
         count_in = QUEUE_CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];
   assign full       = (count_ff == QUEUE_CW'(QUEUE_DEPTH));

   `ASSERT_NEVER(a_pop_empty, clock, reset, pop && (count_ff == '0), "queue popped while empty")
   `ASSERT_PROP(a_count_bound, clock, reset, count_ff <= QUEUE_CW'(QUEUE_DEPTH), "queue count overflow")

endmodule

### hw/rtl/lmts_back.sv
// Back end: glyph store writes, scroll period, image rebuild and row scan.
`include "assert_macros.svh"
module lmts_back import lmts_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  lmts_head_type head,
   output logic          pop,
   lmts_rsp_if.source    rsp_if,
   input  logic [15:0]   scroll_period,
   input  logic [5:0]    char_count
);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_READ_B,
      ST_STEP
   } state_type;

   state_type    state_ff, state_in;
   logic [15:0]  elapsed_ff, elapsed_in;
   logic [2:0]   col_ff, col_in;
   logic [5:0]   pos_ff, pos_in;
   logic [2:0]   scan_ff, scan_in;
   logic [7:0]   shown_ff [8];
   logic [7:0]   shown_in [8];
   logic         slot_valid_ff [SLOTS];
   logic         slot_valid_in [SLOTS];
   logic         a_show_ff, a_show_in;
   logic [4:0]   a_index_ff, a_index_in;
   logic         rd_ok_ff, rd_ok_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   row_sel_ff, row_sel_in;
   logic [7:0]   col_bits_ff, col_bits_in;

   logic               ram_we;
   logic               ram_re;
   logic [SLOT_AW-1:0] ram_raddr;
   lmts_glyph_type     ram_rdata;

   logic [16:0]  tick_next;
   logic         scroll_due;
   logic         out_free;
   logic [6:0]   b_slot;
   logic         a_ok;
   logic         b_ok;
   logic [63:0]  a_rows;
   logic [63:0]  b_rows;
   logic [7:0]   step_rows [8];
   logic [2:0]   col_step;
   logic [5:0]   pos_inc;

   lmts_ram #(
      .WIDTH (GLYPH_W),
      .DEPTH (SLOTS)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (head.entry.slot),
      .wr_data (head.entry.glyph),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      tick_next  = {1'b0, elapsed_ff} + 17'd1;
      scroll_due = (tick_next >= {1'b0, scroll_period});
      out_free   = !rsp_valid_ff || rsp_if.ready;
      b_slot     = {1'b0, pos_ff} + 7'd1;
      a_ok       = (32'(pos_ff) < SLOTS) && slot_valid_ff[SLOT_AW'(pos_ff)];
      b_ok       = (32'(b_slot) < SLOTS) && slot_valid_ff[SLOT_AW'(b_slot)];
      col_step   = col_ff + 3'd1;
      pos_inc    = pos_ff + 6'd1;
   end

   // Rebuilt image: each row is the low byte of {right, left} >> offset.
   always_comb begin
      a_rows = a_show_ff ? font_rows(a_index_ff) : '0;
      b_rows = (rd_ok_ff && ram_rdata.letter) ? font_rows(ram_rdata.index) : '0;
      for (int r = 0; r < 8; r++) begin
         step_rows[r] = 8'({b_rows[8*r +: 8], a_rows[8*r +: 8]} >> col_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      elapsed_in    = elapsed_ff;
      col_in        = col_ff;
      pos_in        = pos_ff;
      scan_in       = scan_ff;
      shown_in      = shown_ff;
      slot_valid_in = slot_valid_ff;
      a_show_in     = a_show_ff;
      a_index_in    = a_index_ff;
      rd_ok_in      = rd_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      row_sel_in    = row_sel_ff;
      col_bits_in   = col_bits_ff;
      pop           = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = SLOT_AW'(pos_ff);

      unique case (state_ff)
         ST_RUN: begin
            if (head.valid) begin
               if (head.entry.is_load) begin
                  pop = 1'b1;
                  if (head.entry.slot_ok) begin
                     ram_we = 1'b1;
                     slot_valid_in[head.entry.slot] = 1'b1;
                  end
               end else if (scroll_due) begin
                  pop        = 1'b1;
                  elapsed_in = '0;
                  ram_re     = 1'b1;
                  ram_raddr  = SLOT_AW'(pos_ff);
                  rd_ok_in   = a_ok;
                  state_in   = ST_READ_B;
               end else if (out_free) begin
                  pop          = 1'b1;
                  elapsed_in   = tick_next[15:0];
                  rsp_valid_in = 1'b1;
                  row_sel_in   = ~(8'd1 << scan_ff);
                  col_bits_in  = shown_ff[scan_ff];
                  scan_in      = scan_ff + 3'd1;
               end
            end
         end
         ST_READ_B: begin
            a_show_in  = rd_ok_ff && ram_rdata.letter;
            a_index_in = ram_rdata.index;
            ram_re     = 1'b1;
            ram_raddr  = SLOT_AW'(b_slot);
            rd_ok_in   = b_ok;
            state_in   = ST_STEP;
         end
         ST_STEP: begin
            if (out_free) begin
               shown_in = step_rows;
               col_in   = col_step;
               if (col_step == 3'd0) begin
                  // slot position wraps to 0 after slot char_count
                  pos_in = ({1'b0, pos_inc} == ({1'b0, char_count} + 7'd1)) ? '0 : pos_inc;
               end
               rsp_valid_in = 1'b1;
               row_sel_in   = ~(8'd1 << scan_ff);
               col_bits_in  = step_rows[scan_ff];
               scan_in      = scan_ff + 3'd1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_show_ff   <= a_show_in;
      a_index_ff  <= a_index_in;
      rd_ok_ff    <= rd_ok_in;
      row_sel_ff  <= row_sel_in;
      col_bits_ff <= col_bits_in;
      if (reset) begin
         state_ff      <= ST_RUN;
         elapsed_ff    <= '0;
         col_ff        <= '0;
         pos_ff        <= '0;
         scan_ff       <= '0;
         shown_ff      <= '{default: '0};
         slot_valid_ff <= '{default: 1'b0};
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         elapsed_ff    <= elapsed_in;
         col_ff        <= col_in;
         pos_ff        <= pos_in;
         scan_ff       <= scan_in;
         shown_ff      <= shown_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.row_select  = row_sel_ff;
   assign rsp_if.column_bits = col_bits_ff;

   `ASSERT_PROP(a_read_b_order, clock, reset, (state_ff == ST_READ_B) |-> ($past(state_ff) == ST_RUN), "second glyph read not preceded by first")
   `ASSERT_NEVER(a_ram_port_clash, clock, reset, ram_we && ram_re, "glyph store written and read in one cycle")
   `ASSERT_PROP(a_row_one_cold, clock, reset, rsp_valid_ff |-> ($countones(row_sel_ff) == 7), "row select not one-cold")
   `ASSERT_NEVER(a_pop_in_step, clock, reset, pop && (state_ff != ST_RUN), "queue popped during scroll step")

endmodule
